// File: sv/bil_pkg.sv
// Shared types and constants for the bilinear integer upscaler.
// Holds the word layouts, register indexes and arithmetic widths.
// No dependencies.
package bil_pkg;

    localparam int DEF_MAX_WIDTH  = 128;
    localparam int DEF_MAX_HEIGHT = 128;

    localparam int PIX_W  = 8;
    localparam int CRD_W  = 10;
    localparam int DIM_W  = 11;
    localparam int CFG_W  = 8;
    localparam int IDX_W  = 2;
    localparam int NX_W   = CRD_W + CFG_W;
    localparam int DEN_W  = 2 * DIM_W;
    localparam int TB_W   = PIX_W + DIM_W;
    localparam int NUMV_W = TB_W + DIM_W;
    localparam int QN_W   = NUMV_W + 1;
    localparam int LANES  = 4;

    localparam logic [IDX_W-1:0] CFG_SCALE  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [IDX_W-1:0] CFG_HEIGHT = 2'd2;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    typedef struct packed {
        logic             action;
        logic [6:0]       in_x;
        logic [6:0]       in_y;
        logic [CRD_W-1:0] out_x;
        logic [CRD_W-1:0] out_y;
        logic [PIX_W-1:0] channel_0;
        logic [PIX_W-1:0] channel_1;
        logic [PIX_W-1:0] channel_2;
        logic [PIX_W-1:0] channel_3;
    } req_t;

    typedef struct packed {
        logic             status;
        logic [PIX_W-1:0] result_channel_0;
        logic [PIX_W-1:0] result_channel_1;
        logic [PIX_W-1:0] result_channel_2;
        logic [PIX_W-1:0] result_channel_3;
        logic [DIM_W-1:0] out_width;
        logic [DIM_W-1:0] out_height;
    } rsp_t;

    typedef struct packed {
        logic [DIM_W-1:0] dx;
        logic [DIM_W-1:0] rx;
        logic [DIM_W-1:0] dy;
        logic [DIM_W-1:0] ry;
        logic [DEN_W-1:0] den;
    } wgt_t;

endpackage

// File: sv/bilinear_integer_upscaler.sv
// Bilinear integer upscaler top level: config, frame store, sequencer, merge.
// Depends on bil_pkg, bil_div and bil_lane.
// Write word: it goes to the finish state, then the result word is registered. Request: the
// two divisions, the store reads, the lane blend, then the registered output word.
// One word in flight; a new word is taken while the previous result waits.
// Reset clears control and config to scale 2, size 1x1; the store is not cleared.
module bilinear_integer_upscaler #(
    parameter int MAX_WIDTH  = bil_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bil_pkg::DEF_MAX_HEIGHT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  bil_pkg::req_t             req_data,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output bil_pkg::rsp_t             rsp_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [bil_pkg::IDX_W-1:0] cfg_index,
    input  logic [bil_pkg::CFG_W-1:0] cfg_data
);
    import bil_pkg::*;

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_LANE  = 3'd3;
    localparam logic [2:0] ST_BLEND = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;

    logic [3:0]       scale_reg;
    logic [CFG_W-1:0] width_reg, height_reg;
    logic [2:0]       state_reg, state_next;
    logic [2:0]       rd_cnt_reg;
    logic             status_reg, blend_reg;
    logic [DIM_W-1:0] dx_reg, dy_reg;
    logic [DEN_W-1:0] den_reg;
    logic [31:0]      pix_reg [LANES];
    logic [31:0]      mem [DEPTH];
    logic [31:0]      mem_q_reg;
    logic             rsp_valid_reg;
    rsp_t             rsp_data_reg;

    logic             accept, geo_ok, wr_bad, rq_bad, mem_we, load_out;
    logic [DIM_W-1:0] ow, oh;
    logic [NX_W-1:0]  nx, ny, qx, qy;
    logic [DIM_W-1:0] rx, ry;
    logic             xbusy, ybusy;
    logic [CFG_W-1:0] wm1, hm1, x0, x1, y0, y1, rdx, rdy;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [LANES-1:0] lane_busy;
    logic [PIX_W-1:0] lane_q [LANES];
    wgt_t             wgt;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg  <= 4'd2;
            width_reg  <= 8'd1;
            height_reg <= 8'd1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SCALE:
                    if (cfg_data[3:0] inside {[4'd2:4'd8]})
                        scale_reg <= cfg_data[3:0];
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        accept = req_valid && !req_stall;
        ow     = DIM_W'(width_reg) * DIM_W'(scale_reg);
        oh     = DIM_W'(height_reg) * DIM_W'(scale_reg);
        geo_ok = width_reg != '0 && int'(width_reg) <= MAX_WIDTH &&
                 height_reg != '0 && int'(height_reg) <= MAX_HEIGHT;
        wr_bad = !geo_ok || CFG_W'(req_data.in_x) >= width_reg ||
                 CFG_W'(req_data.in_y) >= height_reg;
        rq_bad = !geo_ok || DIM_W'(req_data.out_x) >= ow ||
                 DIM_W'(req_data.out_y) >= oh;
        wm1    = width_reg - 1'b1;
        hm1    = height_reg - 1'b1;
        nx     = NX_W'(req_data.out_x) * NX_W'(wm1);
        ny     = NX_W'(req_data.out_y) * NX_W'(hm1);
        mem_we = accept && req_data.action == ACT_WRITE && !wr_bad;
        waddr  = ADDR_W'(ADDR_W'(req_data.in_y) * ADDR_W'(MAX_WIDTH) +
                         ADDR_W'(req_data.in_x));
        x0     = (qx > NX_W'(wm1)) ? wm1 : qx[CFG_W-1:0];
        y0     = (qy > NX_W'(hm1)) ? hm1 : qy[CFG_W-1:0];
        x1     = (x0 >= wm1) ? wm1 : x0 + 1'b1;
        y1     = (y0 >= hm1) ? hm1 : y0 + 1'b1;
        rdx    = rd_cnt_reg[0] ? x1 : x0;
        rdy    = rd_cnt_reg[1] ? y1 : y0;
        raddr  = ADDR_W'(ADDR_W'(rdy) * ADDR_W'(MAX_WIDTH) + ADDR_W'(rdx));
        wgt    = '{dx: dx_reg, rx: rx, dy: dy_reg, ry: ry, den: den_reg};
        load_out = state_reg == ST_FIN && (!rsp_valid_reg || !rsp_stall);
    end

    bil_div #(.NUM_W(NX_W), .DEN_W(DIM_W)) u_div_x (
        .clk(clk), .rst_n(rst_n),
        .start(accept && req_data.action == ACT_READ && !rq_bad),
        .num(nx), .den(ow - 1'b1), .busy(xbusy), .quo(qx), .rem(rx)
    );

    bil_div #(.NUM_W(NX_W), .DEN_W(DIM_W)) u_div_y (
        .clk(clk), .rst_n(rst_n),
        .start(accept && req_data.action == ACT_READ && !rq_bad),
        .num(ny), .den(oh - 1'b1), .busy(ybusy), .quo(qy), .rem(ry)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[waddr] <= {req_data.channel_3, req_data.channel_2,
                           req_data.channel_1, req_data.channel_0};
        mem_q_reg <= mem[raddr];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    if (req_data.action == ACT_WRITE || rq_bad)
                        state_next = ST_FIN;
                    else
                        state_next = ST_DIV;
                end
            ST_DIV:
                if (!xbusy && !ybusy)
                    state_next = ST_READ;
            ST_READ:
                if (rd_cnt_reg == 3'd4)
                    state_next = ST_LANE;
            ST_LANE:
                state_next = ST_BLEND;
            ST_BLEND:
                if (lane_busy == '0)
                    state_next = ST_FIN;
            ST_FIN:
                if (load_out)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_cnt_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_cnt_reg <= (state_reg == ST_READ) ? rd_cnt_reg + 1'b1 : '0;
            if (load_out)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= (req_data.action == ACT_WRITE) ? wr_bad : rq_bad;
            blend_reg  <= req_data.action == ACT_READ && !rq_bad;
            dx_reg     <= ow - 1'b1;
            dy_reg     <= oh - 1'b1;
        end
        if (state_reg == ST_READ)
        begin
            den_reg <= DEN_W'(dx_reg) * DEN_W'(dy_reg);
            if (rd_cnt_reg != 3'd0)
                pix_reg[2'(rd_cnt_reg - 1'b1)] <= mem_q_reg;
        end
        if (load_out)
        begin
            rsp_data_reg.status           <= status_reg;
            rsp_data_reg.result_channel_0 <= blend_reg ? lane_q[0] : '0;
            rsp_data_reg.result_channel_1 <= blend_reg ? lane_q[1] : '0;
            rsp_data_reg.result_channel_2 <= blend_reg ? lane_q[2] : '0;
            rsp_data_reg.result_channel_3 <= blend_reg ? lane_q[3] : '0;
            rsp_data_reg.out_width        <= ow;
            rsp_data_reg.out_height       <= oh;
        end
    end

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        bil_lane u_lane (
            .clk(clk), .rst_n(rst_n),
            .start(state_reg == ST_LANE),
            .wgt(wgt),
            .p00(pix_reg[0][PIX_W*i +: PIX_W]),
            .p10(pix_reg[1][PIX_W*i +: PIX_W]),
            .p01(pix_reg[2][PIX_W*i +: PIX_W]),
            .p11(pix_reg[3][PIX_W*i +: PIX_W]),
            .busy(lane_busy[i]),
            .result(lane_q[i])
        );
    end

    assign req_stall = state_reg != ST_IDLE;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;
endmodule

// File: sv/bil_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on nothing beyond its parameters.
module bil_div #(
    parameter int NUM_W = 18,
    parameter int DEN_W = 11
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [NUM_W-1:0] quo,
    output logic [DEN_W-1:0] rem
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W-1:0] r_reg, r_next;
    logic [DEN_W-1:0] d_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [DEN_W:0]   trial;

    always_comb
    begin
        trial     = {r_reg, q_reg[NUM_W-1]};
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            q_next    = num;
            r_next    = '0;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = DEN_W'(trial - {1'b0, d_reg});
                q_next = {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                r_next = trial[DEN_W-1:0];
                q_next = {q_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        if (start)
            d_reg <= den;
    end

    assign busy = busy_reg;
    assign quo  = q_reg;
    assign rem  = r_reg;
endmodule

// File: sv/bil_lane.sv
// One channel lane: exact bilinear blend and rounded division by den.
// Depends on bil_pkg for widths and the weight struct.
module bil_lane (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  bil_pkg::wgt_t                 wgt,
    input  logic [bil_pkg::PIX_W-1:0]     p00,
    input  logic [bil_pkg::PIX_W-1:0]     p10,
    input  logic [bil_pkg::PIX_W-1:0]     p01,
    input  logic [bil_pkg::PIX_W-1:0]     p11,
    output logic                          busy,
    output logic [bil_pkg::PIX_W-1:0]     result
);
    import bil_pkg::*;

    localparam logic [3:0] CNT_NUM = 4'd9;

    logic [TB_W-1:0]   top_reg, bot_reg;
    logic [QN_W-1:0]   rem_reg, dsh_reg;
    logic [PIX_W-1:0]  q_reg;
    logic [3:0]        cnt_reg;
    logic              busy_reg;
    logic [DIM_W-1:0]  wx0, wy0;
    logic [TB_W-1:0]   top_c, bot_c;
    logic [NUMV_W-1:0] num_c;

    always_comb
    begin
        wx0   = wgt.dx - wgt.rx;
        wy0   = wgt.dy - wgt.ry;
        top_c = TB_W'(p00) * TB_W'(wx0) + TB_W'(p10) * TB_W'(wgt.rx);
        bot_c = TB_W'(p01) * TB_W'(wx0) + TB_W'(p11) * TB_W'(wgt.rx);
        num_c = NUMV_W'(top_reg) * NUMV_W'(wy0) + NUMV_W'(bot_reg) * NUMV_W'(wgt.ry);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_NUM;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == 4'd1)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            top_reg <= top_c;
            bot_reg <= bot_c;
        end
        else if (busy_reg && cnt_reg == CNT_NUM)
        begin
            rem_reg <= {num_c, 1'b0} + QN_W'(wgt.den);
            dsh_reg <= QN_W'({wgt.den, 8'b0});
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_reg <= rem_reg - dsh_reg;
                q_reg   <= {q_reg[PIX_W-2:0], 1'b1};
            end
            else
                q_reg   <= {q_reg[PIX_W-2:0], 1'b0};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign busy   = busy_reg;
    assign result = q_reg;
endmodule

// File: sv/bil_checker.sv
// Port-level checks for the bilinear integer upscaler.
// Depends on bil_pkg; bound to the top level below.
module bil_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input bil_pkg::rsp_t rsp_data
);
    import bil_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
        else $error("stalled result word changed");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("second word taken while busy");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status |->
            rsp_data.result_channel_0 == '0 && rsp_data.result_channel_1 == '0 &&
            rsp_data.result_channel_2 == '0 && rsp_data.result_channel_3 == '0)
        else $error("failed word carries channel data");

    a_ok_dims: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.status |->
            rsp_data.out_width >= DIM_W'(2) && rsp_data.out_height >= DIM_W'(2))
        else $error("good word with empty output size");
endmodule

bind bilinear_integer_upscaler bil_checker u_bil_checker (.*);
